// ===== hdl/trr_pkg.sv =====
// Shared types, codes and constants of the TFTP read receiver.
package trr_pkg;

  localparam int BLOCK_PAYLOAD = 512;

  localparam logic [10:0] HDR_LEN  = 11'd4;
  localparam logic [10:0] FULL_LEN = 11'(BLOCK_PAYLOAD + 4);
  localparam logic [15:0] OPC_DATA = 16'd3;

  localparam logic [3:0]  RETRY_RESET    = 4'd3;
  localparam logic [15:0] TFTP_PORT      = 16'd69;
  localparam logic [31:0] SERVER_ADDR_RST = 32'd0;

  // Configuration register indexes
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_SERVER_PORT = 2'd1;
  localparam logic [1:0] CFG_SERVER_ADDR = 2'd2;

  // Event codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_FAIL   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Send kinds
  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] SEND_RRQ  = 2'd1;
  localparam logic [1:0] SEND_ACK  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_REQ  = 3'b010,
    PH_XFER = 3'b100
  } phase_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [15:0] server_port;
    logic [31:0] server_address;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [10:0] packet_length;
    logic [15:0] packet_opcode;
    logic [15:0] packet_block;
    logic [15:0] packet_source_port;
  } item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [15:0] send_block;
    logic [15:0] dest_port;
    logic [31:0] dest_address;
    logic        write_enable;
    logic [15:0] write_index;
    logic [10:0] write_length;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] expected_block;
    logic [15:0] peer_port;
    logic [3:0]  failure_count;
  } ctx_t;

endpackage

// ===== hdl/tftp_read_receiver.sv =====
// Top level of the TFTP read receiver: handshakes, event register, state and result register.
//
// One event (start, packet received, attempt failed) enters per transaction on the input
// channel and yields exactly one result transaction. An event is captured in an input
// register, decided by one level of logic in the next cycle, and the decision is written to
// the result register together with the transfer state (phase, expected block, locked peer
// port, failure count). An accepted event moves on from the input register into the result
// register when that register is free, and the block sustains one event per cycle while results are taken: the input
// register advances whenever the result register is empty or being taken, so a new event is
// accepted into an empty input register while a finished result still
// waits. The state update happens as an event leaves the input register, so the following
// event always sees it. Configuration (retry limit, server port, server address) is written
// through its own channel, which is always ready, and must only be written while no event is
// in flight.
module tftp_read_receiver (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // events
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [10:0] packet_length,
  input  logic [15:0] packet_opcode,
  input  logic [15:0] packet_block,
  input  logic [15:0] packet_source_port,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  send_kind,
  output logic [15:0] send_block,
  output logic [15:0] dest_port,
  output logic [31:0] dest_address,
  output logic        write_enable,
  output logic [15:0] write_index,
  output logic [10:0] write_length,
  output logic [1:0]  status
);

  trr_pkg::cfg_t    cfg;
  trr_pkg::ctx_t    ctx;
  trr_pkg::ctx_t    ctx_next;
  trr_pkg::item_t   s1_item;
  trr_pkg::result_t res_next;
  trr_pkg::result_t out_res;
  logic             s1_valid;
  logic             advance;

  trr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trr_decide u_decide (
    .cfg      (cfg),
    .ctx      (ctx),
    .item     (s1_item),
    .ctx_next (ctx_next),
    .res      (res_next)
  );

  // Move the held event into the result register when that register frees up.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register: capture each transaction, hold it until decided.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.operation          <= operation;
      s1_item.packet_length      <= packet_length;
      s1_item.packet_opcode      <= packet_opcode;
      s1_item.packet_block       <= packet_block;
      s1_item.packet_source_port <= packet_source_port;
    end
  end

  // Transfer state: advance only together with the result it produced.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.phase          <= trr_pkg::PH_IDLE;
      ctx.expected_block <= 16'd0;
      ctx.peer_port      <= 16'd0;
      ctx.failure_count  <= 4'd0;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  // Result register: hold a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign send_kind    = out_res.send_kind;
  assign send_block   = out_res.send_block;
  assign dest_port    = out_res.dest_port;
  assign dest_address = out_res.dest_address;
  assign write_enable = out_res.write_enable;
  assign write_index  = out_res.write_index;
  assign write_length = out_res.write_length;
  assign status       = out_res.status;

`ifndef ASSERT_OFF
  // A held event is never dropped while the result register is blocked.
  a_hold_event: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("event lost in input register");

  // Ending a transfer returns the phase to idle.
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    advance && (res_next.status != trr_pkg::ST_BUSY) |=> ctx.phase == trr_pkg::PH_IDLE)
    else $error("transfer ended but phase not idle");

  // A failure never sends anything.
  a_fail_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == trr_pkg::ST_FAIL) |-> send_kind == trr_pkg::SEND_NONE)
    else $error("failure result carries a send");

  // A flash write always comes with an ACK and a nonzero length.
  a_write_acked: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> (send_kind == trr_pkg::SEND_ACK) && (write_length != 11'd0))
    else $error("flash write without ACK or with zero length");

  // Reset empties the input register and the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== hdl/trr_cfg.sv =====
// Configuration register file of the TFTP read receiver.
module trr_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output trr_pkg::cfg_t      cfg
);

  trr_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.retry_limit    <= trr_pkg::RETRY_RESET;
      regs.server_port    <= trr_pkg::TFTP_PORT;
      regs.server_address <= trr_pkg::SERVER_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        trr_pkg::CFG_RETRY_LIMIT: regs.retry_limit    <= cfg_data[3:0];
        trr_pkg::CFG_SERVER_PORT: regs.server_port    <= cfg_data[15:0];
        trr_pkg::CFG_SERVER_ADDR: regs.server_address <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

// ===== hdl/trr_decide.sv =====
// Per-event decision logic: next transfer state and the result of one event.
module trr_decide (
  input  trr_pkg::cfg_t    cfg,
  input  trr_pkg::ctx_t    ctx,
  input  trr_pkg::item_t   item,
  output trr_pkg::ctx_t    ctx_next,
  output trr_pkg::result_t res
);

  logic [3:0]  fc_inc;
  logic [15:0] ack_blk;
  logic [15:0] lock_port;
  logic        active;
  logic [1:0]  kind;

  always_comb begin
    fc_inc    = ctx.failure_count + 4'd1;
    ack_blk   = ctx.expected_block - 16'd1;
    lock_port = (ctx.phase == trr_pkg::PH_REQ) ? item.packet_source_port : ctx.peer_port;
    active    = (ctx.phase == trr_pkg::PH_REQ) || (ctx.phase == trr_pkg::PH_XFER);
    ctx_next  = ctx;
    res       = '0;

    case (item.operation)
      trr_pkg::OP_START: begin
        ctx_next.phase          = trr_pkg::PH_REQ;
        ctx_next.expected_block = 16'd1;
        ctx_next.peer_port      = 16'd0;
        ctx_next.failure_count  = 4'd0;
        res.send_kind           = trr_pkg::SEND_RRQ;
        res.dest_port           = cfg.server_port;
      end
      trr_pkg::OP_PACKET, trr_pkg::OP_FAIL: begin
        if (active) begin
          if (item.operation == trr_pkg::OP_FAIL || item.packet_length < trr_pkg::HDR_LEN) begin
            ctx_next.failure_count = fc_inc;
            if (fc_inc >= cfg.retry_limit) begin
              ctx_next.phase = trr_pkg::PH_IDLE;
              res.status     = trr_pkg::ST_FAIL;
            end else if (ctx.phase == trr_pkg::PH_REQ) begin
              res.send_kind = trr_pkg::SEND_RRQ;
              res.dest_port = cfg.server_port;
            end else begin
              res.send_kind  = trr_pkg::SEND_ACK;
              res.send_block = ack_blk;
              res.dest_port  = ctx.peer_port;
            end
          end else begin
            ctx_next.failure_count = 4'd0;
            if (item.packet_opcode != trr_pkg::OPC_DATA) begin
              ctx_next.phase = trr_pkg::PH_IDLE;
              res.status     = trr_pkg::ST_FAIL;
            end else if (item.packet_block != ctx.expected_block) begin
              if (ctx.phase == trr_pkg::PH_REQ) begin
                // first block missing: lock the port anyway, then give up
                ctx_next.peer_port = item.packet_source_port;
                ctx_next.phase     = trr_pkg::PH_IDLE;
                res.status         = trr_pkg::ST_FAIL;
              end else begin
                res.send_kind  = trr_pkg::SEND_ACK;
                res.send_block = ack_blk;
                res.dest_port  = ctx.peer_port;
              end
            end else begin
              ctx_next.peer_port      = lock_port;
              ctx_next.expected_block = ctx.expected_block + 16'd1;
              if (item.packet_length > trr_pkg::HDR_LEN) begin
                res.write_enable = 1'b1;
                res.write_index  = ack_blk;
                res.write_length = item.packet_length - trr_pkg::HDR_LEN;
              end
              res.send_kind  = trr_pkg::SEND_ACK;
              res.send_block = item.packet_block;
              res.dest_port  = lock_port;
              if (item.packet_length >= trr_pkg::FULL_LEN) begin
                ctx_next.phase = trr_pkg::PH_XFER;
              end else begin
                ctx_next.phase = trr_pkg::PH_IDLE;
                res.status     = trr_pkg::ST_DONE;
              end
            end
          end
        end
      end
      default: ;  // unused event code gives an all-zero result
    endcase

    kind = res.send_kind;
    res.dest_address = (kind != trr_pkg::SEND_NONE) ? cfg.server_address : 32'd0;
  end

endmodule

// ===== test/tftp_read_receiver_tb.sv =====
// Self-checking testbench for the TFTP read receiver, with an event-by-event transfer model.
`timescale 1ns / 1ps

class transfer_scoreboard;
  // register copies
  logic [3:0]  retry_limit;
  logic [15:0] server_port;
  logic [31:0] server_address;
  // transfer state copies
  trr_pkg::phase_t phase;
  logic [15:0] expected_block;
  logic [15:0] peer_port;
  logic [3:0]  failure_count;

  trr_pkg::result_t expected_q[$];
  int          errors;

  function new();
    retry_limit    = trr_pkg::RETRY_RESET;
    server_port    = trr_pkg::TFTP_PORT;
    server_address = trr_pkg::SERVER_ADDR_RST;
    phase          = trr_pkg::PH_IDLE;
    expected_block = '0;
    peer_port      = '0;
    failure_count  = '0;
    errors         = 0;
  endfunction

  function void write_register(logic [1:0] idx, logic [31:0] data);
    case (idx)
      trr_pkg::CFG_RETRY_LIMIT: retry_limit = data[3:0];
      trr_pkg::CFG_SERVER_PORT: server_port = data[15:0];
      trr_pkg::CFG_SERVER_ADDR: server_address = data;
      default: ;
    endcase
  endfunction

  function trr_pkg::result_t make_result(logic [1:0] kind, logic [15:0] blk,
                                         logic [15:0] port, logic wen, logic [15:0] widx,
                                         logic [10:0] wlen, logic [1:0] st);
    trr_pkg::result_t r;
    r.send_kind    = kind;
    r.send_block   = blk;
    r.dest_port    = port;
    r.dest_address = (kind != trr_pkg::SEND_NONE) ? server_address : 32'd0;
    r.write_enable = wen;
    r.write_index  = widx;
    r.write_length = wlen;
    r.status       = st;
    return r;
  endfunction

  // Repeat the last message: the request until DATA shows up, the current ACK after.
  function trr_pkg::result_t retransmit();
    if (phase == trr_pkg::PH_REQ)
      return make_result(trr_pkg::SEND_RRQ, '0, server_port, 1'b0, '0, '0, trr_pkg::ST_BUSY);
    return make_result(trr_pkg::SEND_ACK, expected_block - 16'd1, peer_port, 1'b0, '0, '0,
                       trr_pkg::ST_BUSY);
  endfunction

  function trr_pkg::result_t abort();
    phase = trr_pkg::PH_IDLE;
    return make_result(trr_pkg::SEND_NONE, '0, '0, 1'b0, '0, '0, trr_pkg::ST_FAIL);
  endfunction

  function void note_event(trr_pkg::item_t ev);
    trr_pkg::result_t r;
    bit      in_transfer;
    logic    wen;
    in_transfer = (phase == trr_pkg::PH_REQ) || (phase == trr_pkg::PH_XFER);
    r = make_result(trr_pkg::SEND_NONE, '0, '0, 1'b0, '0, '0, trr_pkg::ST_BUSY);
    if (ev.operation == trr_pkg::OP_START) begin
      phase          = trr_pkg::PH_REQ;
      expected_block = 16'd1;
      peer_port      = '0;
      failure_count  = '0;
      r = make_result(trr_pkg::SEND_RRQ, '0, server_port, 1'b0, '0, '0, trr_pkg::ST_BUSY);
    end else if (ev.operation == trr_pkg::OP_UNUSED || !in_transfer) begin
      // ignored: all-zero result
    end else if (ev.operation == trr_pkg::OP_FAIL || ev.packet_length < trr_pkg::HDR_LEN) begin
      failure_count = failure_count + 4'd1;
      r = (failure_count >= retry_limit) ? abort() : retransmit();
    end else begin
      failure_count = '0;
      if (ev.packet_opcode != trr_pkg::OPC_DATA ||
          (phase == trr_pkg::PH_REQ && ev.packet_block != expected_block)) begin
        r = abort();
      end else if (ev.packet_block != expected_block) begin
        r = retransmit();
      end else begin
        if (phase == trr_pkg::PH_REQ)
          peer_port = ev.packet_source_port;
        phase = trr_pkg::PH_XFER;
        wen = ev.packet_length > trr_pkg::HDR_LEN;
        r = make_result(trr_pkg::SEND_ACK, ev.packet_block, peer_port, wen,
                        wen ? expected_block - 16'd1 : 16'd0,
                        wen ? ev.packet_length - trr_pkg::HDR_LEN : 11'd0,
                        (ev.packet_length < trr_pkg::FULL_LEN) ? trr_pkg::ST_DONE
                                                               : trr_pkg::ST_BUSY);
        expected_block = expected_block + 16'd1;
        if (ev.packet_length < trr_pkg::FULL_LEN)
          phase = trr_pkg::PH_IDLE;
      end
    end
    expected_q.push_back(r);
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(trr_pkg::result_t got);
    trr_pkg::result_t want;
    if (expected_q.size() == 0) begin
      $error("result transaction with no event pending");
      errors++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("send_kind", want.send_kind, got.send_kind);
    compare_field("send_block", want.send_block, got.send_block);
    compare_field("dest_port", want.dest_port, got.dest_port);
    compare_field("dest_address", want.dest_address, got.dest_address);
    compare_field("write_enable", want.write_enable, got.write_enable);
    compare_field("write_index", want.write_index, got.write_index);
    compare_field("write_length", want.write_length, got.write_length);
    compare_field("status", want.status, got.status);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tftp_read_receiver_tb;

  localparam int         RANDOM_ITEMS   = 1000;
  localparam int         HOLD_OFF_LEN   = 400;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         CYCLE_LIMIT    = 1_000_000;
  localparam int         LONG_BLOCKS    = 24;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [10:0] packet_length;
  logic [15:0] packet_opcode;
  logic [15:0] packet_block;
  logic [15:0] packet_source_port;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  send_kind;
  logic [15:0] send_block;
  logic [15:0] dest_port;
  logic [31:0] dest_address;
  logic        write_enable;
  logic [15:0] write_index;
  logic [10:0] write_length;
  logic [1:0]  status;

  transfer_scoreboard sb;
  trr_pkg::item_t     batch[$];
  bit                 no_gaps;
  bit                 hold_off_pending;
  int                 cycle_count;
  int                 sink_stall;

  tftp_read_receiver DUT (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .operation          (operation),
    .packet_length      (packet_length),
    .packet_opcode      (packet_opcode),
    .packet_block       (packet_block),
    .packet_source_port (packet_source_port),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .send_kind          (send_kind),
    .send_block         (send_block),
    .dest_port          (dest_port),
    .dest_address       (dest_address),
    .write_enable       (write_enable),
    .write_index        (write_index),
    .write_length       (write_length),
    .status             (status)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Bound the run; a hung handshake lands here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tftp_read_receiver_tb NOT OK");
      $finish;
    end
  end

  // Sample both channels on the edge itself: every value read here was settled before it.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_event(trr_pkg::item_t'({operation, packet_length, packet_opcode, packet_block,
                                      packet_source_port}));
    if (!rst && out_valid && out_ready)
      sb.check_result(trr_pkg::result_t'({send_kind, send_block, dest_port, dest_address,
                                          write_enable, write_index, write_length, status}));
  end

  // Result side: stall a random number of cycles before each transaction, and once hold
  // off for a long stretch so the block backs up into its input.
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      sink_stall = no_gaps ? 0 : $urandom_range(0, 10);
      if (hold_off_pending) begin
        sink_stall       = HOLD_OFF_LEN;
        hold_off_pending = 1'b0;
      end
      if (sink_stall > 0) begin
        out_ready <= 1'b0;
        repeat (sink_stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic void add_event(logic [1:0] op, int len, int opc, int blk, int sport);
    trr_pkg::item_t ev;
    ev.operation          = op;
    ev.packet_length      = 11'(len);
    ev.packet_opcode      = 16'(opc);
    ev.packet_block       = 16'(blk);
    ev.packet_source_port = 16'(sport);
    batch.push_back(ev);
  endfunction

  // Random-content noise: any operation, any field values.
  function automatic void add_noise(int count);
    for (int i = 0; i < count; i++)
      add_event(2'($urandom_range(0, 3)), $urandom_range(0, 2047), $urandom, $urandom,
                $urandom);
  endfunction

  // One transfer: a start and a run of in-sequence DATA blocks ending in a short one,
  // with timeouts, runt packets, duplicates and the odd fatal packet mixed in.
  function automatic void add_transfer();
    int n_blocks;
    int sport;
    int len;
    int opc;
    n_blocks = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
    sport    = $urandom_range(0, 65535);
    add_event(trr_pkg::OP_START, $urandom_range(0, 2047), $urandom, $urandom, $urandom);
    for (int b = 1; b <= n_blocks; b++) begin
      case ($urandom_range(0, 19))
        0: add_event(trr_pkg::OP_FAIL, $urandom_range(0, 2047), $urandom, $urandom, $urandom);
        1: add_event(trr_pkg::OP_PACKET, $urandom_range(0, 3), $urandom, $urandom, $urandom);
        2: add_event(trr_pkg::OP_PACKET, $urandom_range(4, 2047), trr_pkg::OPC_DATA,
                     ($urandom_range(0, 1) == 0) ? b - 1 : $urandom_range(0, 65535), sport);
        3: begin
          if ($urandom_range(0, 3) == 0) begin
            opc = $urandom_range(0, 65535);
            if (opc == trr_pkg::OPC_DATA)
              opc = 5;
            add_event(trr_pkg::OP_PACKET, $urandom_range(4, 2047), opc, b, sport);
          end
        end
        4: begin
          if (b == 1 && $urandom_range(0, 1) == 0)
            add_event(trr_pkg::OP_PACKET, trr_pkg::FULL_LEN, trr_pkg::OPC_DATA,
                      $urandom_range(2, 65535), sport);
        end
        default: ;
      endcase
      if (b == n_blocks)
        len = $urandom_range(4, trr_pkg::FULL_LEN - 1);
      else
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(trr_pkg::FULL_LEN, 2047)
                                          : trr_pkg::FULL_LEN;
      add_event(trr_pkg::OP_PACKET, len, trr_pkg::OPC_DATA, b,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : sport);
    end
  endfunction

  // Offer every queued event in turn; hold each until accepted, drop valid at the end.
  task automatic send_batch();
    int gap;
    foreach (batch[i]) begin
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid           <= 1'b1;
      operation          <= batch[i].operation;
      packet_length      <= batch[i].packet_length;
      packet_opcode      <= batch[i].packet_opcode;
      packet_block       <= batch[i].packet_block;
      packet_source_port <= batch[i].packet_source_port;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    batch.delete();
    @(posedge clk);
  endtask

  // Every event yields a result, so an empty queue plus the pipeline depth means idle.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(logic [3:0] retry, logic [15:0] port, logic [31:0] addr);
    logic [1:0]  idx [3];
    logic [31:0] value [3];
    idx   = '{trr_pkg::CFG_RETRY_LIMIT, trr_pkg::CFG_SERVER_PORT, trr_pkg::CFG_SERVER_ADDR};
    value = '{{28'd0, retry}, {16'd0, port}, addr};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= value[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_register(idx[i], value[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [3:0]  retry;
    logic [15:0] port;
    logic [31:0] addr;
    int          sent;
    int          round;

    rst                = 1'b1;
    cfg_valid          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_valid           = 1'b0;
    operation          = '0;
    packet_length      = '0;
    packet_opcode      = '0;
    packet_block       = '0;
    packet_source_port = '0;
    no_gaps            = 1'b0;
    hold_off_pending   = 1'b0;
    cycle_count        = 0;
    sb                 = new();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, on reset register values: events while idle, retries running out,
    // a missing first block, a non-DATA packet, duplicate, empty and overlong blocks.
    add_event(trr_pkg::OP_PACKET, 2047, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_event(trr_pkg::OP_FAIL, 0, 0, 0, 0);
    add_event(trr_pkg::OP_UNUSED, 2047, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_event(trr_pkg::OP_START, 0, 0, 0, 0);
    add_event(trr_pkg::OP_PACKET, 3, trr_pkg::OPC_DATA, 1, 1000);
    add_event(trr_pkg::OP_FAIL, 0, 0, 0, 0);
    add_event(trr_pkg::OP_FAIL, 0, 0, 0, 0);
    add_event(trr_pkg::OP_START, 0, 0, 0, 0);
    add_event(trr_pkg::OP_PACKET, trr_pkg::FULL_LEN, trr_pkg::OPC_DATA, 2, 1234);
    add_event(trr_pkg::OP_START, 0, 0, 0, 0);
    add_event(trr_pkg::OP_PACKET, trr_pkg::FULL_LEN, 5, 1, 1234);
    add_event(trr_pkg::OP_START, 0, 0, 0, 0);
    add_event(trr_pkg::OP_PACKET, trr_pkg::FULL_LEN, trr_pkg::OPC_DATA, 1, 16'hFFFF);
    add_event(trr_pkg::OP_UNUSED, 0, 0, 0, 0);
    add_event(trr_pkg::OP_PACKET, 100, trr_pkg::OPC_DATA, 1, 16'hFFFF);
    add_event(trr_pkg::OP_PACKET, 4, trr_pkg::OPC_DATA, 2, 0);
    add_event(trr_pkg::OP_START, 0, 0, 0, 0);
    add_event(trr_pkg::OP_PACKET, 2047, trr_pkg::OPC_DATA, 1, 0);
    add_event(trr_pkg::OP_START, 0, 0, 0, 0);
    add_event(trr_pkg::OP_PACKET, 0, 0, 0, 0);
    add_event(trr_pkg::OP_PACKET, trr_pkg::FULL_LEN - 1, trr_pkg::OPC_DATA, 1, 777);
    send_batch();
    wait_idle();

    // Zero retry limit: the first failed attempt ends the transfer.
    write_settings(4'd0, 16'd0, 32'hFFFF_FFFF);
    add_event(trr_pkg::OP_START, 0, 0, 0, 0);
    add_event(trr_pkg::OP_FAIL, 0, 0, 0, 0);
    add_event(trr_pkg::OP_START, 0, 0, 0, 0);
    add_event(trr_pkg::OP_PACKET, trr_pkg::FULL_LEN, trr_pkg::OPC_DATA, 1, 4321);
    add_event(trr_pkg::OP_PACKET, 2, trr_pkg::OPC_DATA, 2, 4321);
    send_batch();
    wait_idle();

    // Long back-to-back transfer of full blocks.
    write_settings(4'd15, 16'($urandom), $urandom);
    no_gaps = 1'b1;
    add_event(trr_pkg::OP_START, 0, 0, 0, 0);
    for (int b = 1; b <= LONG_BLOCKS; b++)
      add_event(trr_pkg::OP_PACKET, trr_pkg::FULL_LEN, trr_pkg::OPC_DATA, b, 2000);
    add_event(trr_pkg::OP_PACKET, 100, trr_pkg::OPC_DATA, LONG_BLOCKS + 1, 2000);
    send_batch();
    no_gaps = 1'b0;
    wait_idle();

    // Random transfers with noise between them; change registers every few rounds.
    sent  = 0;
    round = 0;
    while (sent < RANDOM_ITEMS) begin
      if (round % 4 == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: retry = 4'd0;
          1: retry = 4'd1;
          2: retry = 4'd15;
          default: retry = 4'($urandom_range(1, 15));
        endcase
        case ($urandom_range(0, 2))
          0: port = 16'd0;
          1: port = 16'hFFFF;
          default: port = 16'($urandom);
        endcase
        case ($urandom_range(0, 2))
          0: addr = 32'd0;
          1: addr = 32'hFFFF_FFFF;
          default: addr = $urandom;
        endcase
        write_settings(retry, port, addr);
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      if (round == 6) begin
        no_gaps          = 1'b0;
        hold_off_pending = 1'b1;
      end
      add_noise($urandom_range(0, 2));
      add_transfer();
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 15)) add_event(trr_pkg::OP_FAIL, 0, 0, 0, 0);
      sent += batch.size();
      send_batch();
      round++;
    end
    no_gaps = 1'b0;

    wait_idle();
    if (sb.errors == 0)
      $display("tftp_read_receiver_tb OK");
    else
      $display("tftp_read_receiver_tb NOT OK");
    $finish;
  end

endmodule
